[hdl/sdft_pkg.sv]
// Shared types, constants and functions of the per-pixel sliding DFT unit.
package sdft_pkg;

  // Default geometry, handed to the top-level parameters
  localparam int WINDOW_LEN_DEF   = 15;
  localparam int FRAME_WIDTH_DEF  = 64;
  localparam int FRAME_HEIGHT_DEF = 64;

  // Channel and bin limits
  localparam int NCHAN     = 3;
  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;
  localparam int MAX_BINS  = 8;
  localparam int BIN_IDX_W = 3;
  localparam logic [BIN_IDX_W-1:0] DC_BIN = 3'd0;

  // Twiddle format and rounding
  localparam int TW_FRAC     = 15;
  localparam int TAYLOR_FRAC = 28;
  localparam int TAYLOR_TERMS = 30;

  // Output queue sizing
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef logic signed [31:0] coef_t;
  typedef logic signed [16:0] diff_t;
  typedef diff_t [NCHAN-1:0] diff_vec_t;
  typedef logic [MAX_BINS-1:0][15:0] twiddle_rom_t;

  // One memory row: real and imaginary part of one bin of one pixel, all channels
  typedef struct packed {
    coef_t [NCHAN-1:0] re;
    coef_t [NCHAN-1:0] im;
  } coef_row_t;

  // Control tag that travels with each bin through the datapath
  typedef struct packed {
    logic                 valid;
    logic [BIN_IDX_W-1:0] bin;
    logic                 last;
  } bin_tag_t;

  // Datapath occupancy and pixel match, seen by the sequencer
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic pix_hit;
  } pipe_status_t;

  // One result item
  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    coef_t [NCHAN-1:0]    re;
    coef_t [NCHAN-1:0]    im;
    logic                 last_bin;
  } bin_result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Clamp a wide signed value into 32 bits
  function automatic coef_t sat32(input logic signed [35:0] v);
    coef_t r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Unsigned quotient by shift and subtract, for building the constant tables
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Cos or sin table for bins 0..MAX_BINS-1, Taylor series in Q28, rounded to Q1.15
  function automatic twiddle_rom_t twiddle_rom(input int n_len, input logic want_sin);
    twiddle_rom_t      rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   tc;
    longint unsigned   ts;
    longint unsigned   den;
    longint            c;
    longint            s;
    longint            v;
    longint            r;
    rom = '0;
    for (int k = 0; k < MAX_BINS; k++) begin
      den = longint'(100000) * longint'(n_len);
      x   = udiv64((longint'(628318) * longint'(k)) << TAYLOR_FRAC, den);
      x2  = (x * x) >> TAYLOR_FRAC;
      tc  = longint'(1) << TAYLOR_FRAC;
      ts  = x;
      c   = 0;
      s   = 0;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        if (n % 2 == 1) begin
          c = c - longint'(tc);
          s = s - longint'(ts);
        end else begin
          c = c + longint'(tc);
          s = s + longint'(ts);
        end
        tc = udiv64((tc * x2) >> TAYLOR_FRAC, longint'((2 * n + 1) * (2 * n + 2)));
        ts = udiv64((ts * x2) >> TAYLOR_FRAC, longint'((2 * n + 2) * (2 * n + 3)));
      end
      v = want_sin ? s : c;
      r = (v + (longint'(1) << (TAYLOR_FRAC - TW_FRAC - 1))) >>> (TAYLOR_FRAC - TW_FRAC);
      if (r > 32767) begin
        r = 32767;
      end
      if (r < -32768) begin
        r = -32768;
      end
      rom[k] = r[15:0];
    end
    return rom;
  endfunction

endpackage

[hdl/sdft_channels.sv]
// Pixel input and bin result channel interfaces.
interface sdft_pix_if;
  logic               valid;
  logic               ready;
  logic [5:0]         pixel_x;
  logic [5:0]         pixel_y;
  logic signed [15:0] new_red;
  logic signed [15:0] new_green;
  logic signed [15:0] new_blue;
  logic signed [15:0] old_red;
  logic signed [15:0] old_green;
  logic signed [15:0] old_blue;

  modport source (
    output valid, pixel_x, pixel_y, new_red, new_green, new_blue,
           old_red, old_green, old_blue,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, new_red, new_green, new_blue,
           old_red, old_green, old_blue,
    output ready
  );
endinterface

interface sdft_bin_if;
  logic               valid;
  logic               ready;
  logic [2:0]         bin_index;
  logic signed [31:0] real_red;
  logic signed [31:0] real_green;
  logic signed [31:0] real_blue;
  logic signed [31:0] imag_red;
  logic signed [31:0] imag_green;
  logic signed [31:0] imag_blue;
  logic               last_bin;

  modport source (
    output valid, bin_index, real_red, real_green, real_blue,
           imag_red, imag_green, imag_blue, last_bin,
    input  ready
  );
  modport sink (
    input  valid, bin_index, real_red, real_green, real_blue,
           imag_red, imag_green, imag_blue, last_bin,
    output ready
  );
endinterface

[hdl/sdft_coef_ram.sv]
// Coefficient memory: one write port, one registered read port.
module sdft_coef_ram #(
  parameter int ADDR_W = 15
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  sdft_pkg::coef_row_t   wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output sdft_pkg::coef_row_t   rdata
);

  sdft_pkg::coef_row_t mem [2**ADDR_W];

  // Write the row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read row
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sdft_bin_datapath.sv]
// Two-stage bin update: twiddle products, then round, saturate and write back.
module sdft_bin_datapath #(
  parameter int WINDOW_LEN = sdft_pkg::WINDOW_LEN_DEF,
  parameter int ADDR_W     = 15,
  parameter int BIN_W      = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sdft_pkg::bin_tag_t         issue_tag,
  input  logic [ADDR_W-1:0]          issue_addr,
  input  sdft_pkg::diff_vec_t        issue_diff,
  input  sdft_pkg::coef_row_t        rd_data,
  input  logic [ADDR_W-BIN_W-1:0]    probe_pix,
  output logic                       wb_en,
  output logic [ADDR_W-1:0]          wb_addr,
  output sdft_pkg::coef_row_t        wb_data,
  output logic                       res_valid,
  output sdft_pkg::bin_result_t      res,
  output sdft_pkg::pipe_status_t     status
);

  localparam sdft_pkg::twiddle_rom_t COS_ROM = sdft_pkg::twiddle_rom(WINDOW_LEN, 1'b0);
  localparam sdft_pkg::twiddle_rom_t SIN_ROM = sdft_pkg::twiddle_rom(WINDOW_LEN, 1'b1);
  localparam int ROUND_HALF = 2 ** (sdft_pkg::TW_FRAC - 1);

  // Stage 1 registers: tag, address and sample differences of the bin being read
  sdft_pkg::bin_tag_t   s1_tag;
  logic [ADDR_W-1:0]    s1_addr;
  sdft_pkg::diff_vec_t  s1_diff;

  // Stage 1 logic
  logic signed [15:0] cs;
  logic signed [15:0] sn;
  logic signed [32:0] t1  [sdft_pkg::NCHAN];
  logic signed [48:0] pct [sdft_pkg::NCHAN];
  logic signed [47:0] psp [sdft_pkg::NCHAN];
  logic signed [48:0] pst [sdft_pkg::NCHAN];
  logic signed [47:0] pcp [sdft_pkg::NCHAN];

  // Stage 2 registers
  sdft_pkg::bin_tag_t   s2_tag;
  logic [ADDR_W-1:0]    s2_addr;
  logic signed [32:0]   s2_t   [sdft_pkg::NCHAN];
  logic signed [48:0]   s2_pct [sdft_pkg::NCHAN];
  logic signed [47:0]   s2_psp [sdft_pkg::NCHAN];
  logic signed [48:0]   s2_pst [sdft_pkg::NCHAN];
  logic signed [47:0]   s2_pcp [sdft_pkg::NCHAN];

  // Stage 2 logic
  logic signed [50:0]   re_acc [sdft_pkg::NCHAN];
  logic signed [50:0]   im_acc [sdft_pkg::NCHAN];
  sdft_pkg::coef_t      re_out [sdft_pkg::NCHAN];
  sdft_pkg::coef_t      im_out [sdft_pkg::NCHAN];

  // Capture the issued bin alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else begin
      s1_tag <= issue_tag;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= issue_addr;
    s1_diff <= issue_diff;
  end

  // Form t = re + new - old and the four twiddle products per channel
  always_comb begin
    cs = $signed(COS_ROM[s1_tag.bin]);
    sn = $signed(SIN_ROM[s1_tag.bin]);
    for (int c = 0; c < sdft_pkg::NCHAN; c++) begin
      t1[c]  = 33'($signed(rd_data.re[c])) + 33'($signed(s1_diff[c]));
      pct[c] = 49'(cs) * 49'(t1[c]);
      psp[c] = 48'(sn) * 48'($signed(rd_data.im[c]));
      pst[c] = 49'(sn) * 49'(t1[c]);
      pcp[c] = 48'(cs) * 48'($signed(rd_data.im[c]));
    end
  end

  // Advance products into stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else begin
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr <= s1_addr;
    for (int c = 0; c < sdft_pkg::NCHAN; c++) begin
      s2_t[c]   <= t1[c];
      s2_pct[c] <= pct[c];
      s2_psp[c] <= psp[c];
      s2_pst[c] <= pst[c];
      s2_pcp[c] <= pcp[c];
    end
  end

  // Sum, round to nearest, saturate; DC passes t through the clamp
  always_comb begin
    for (int c = 0; c < sdft_pkg::NCHAN; c++) begin
      re_acc[c] = 51'(s2_pct[c]) - 51'(s2_psp[c]) + 51'(ROUND_HALF);
      im_acc[c] = 51'(s2_pst[c]) + 51'(s2_pcp[c]) + 51'(ROUND_HALF);
      if (s2_tag.bin == sdft_pkg::DC_BIN) begin
        re_out[c] = sdft_pkg::sat32(36'(s2_t[c]));
        im_out[c] = '0;
      end else begin
        re_out[c] = sdft_pkg::sat32(re_acc[c][50:15]);
        im_out[c] = sdft_pkg::sat32(im_acc[c][50:15]);
      end
    end
  end

  // Write back and hand the result to the output queue
  always_comb begin
    wb_en         = s2_tag.valid;
    wb_addr       = s2_addr;
    res_valid     = s2_tag.valid;
    res.bin_index = s2_tag.bin;
    res.last_bin  = s2_tag.last;
    for (int c = 0; c < sdft_pkg::NCHAN; c++) begin
      wb_data.re[c] = re_out[c];
      wb_data.im[c] = im_out[c];
      res.re[c]     = re_out[c];
      res.im[c]     = im_out[c];
    end
  end

  // Report occupancy and whether a bin of the probed pixel is still in flight
  always_comb begin
    status.s1_valid = s1_tag.valid;
    status.s2_valid = s2_tag.valid;
    status.pix_hit  = (s1_tag.valid && (s1_addr[ADDR_W-1:BIN_W] == probe_pix)) ||
                      (s2_tag.valid && (s2_addr[ADDR_W-1:BIN_W] == probe_pix));
  end

endmodule

[hdl/sdft_out_queue.sv]
// Small result queue that drives the bin output channel.
module sdft_out_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  sdft_pkg::bin_result_t               push_data,
  output logic [sdft_pkg::OUTQ_CNT_W-1:0]     count,
  sdft_bin_if.source                          bin_out
);

  localparam int PTR_W = $clog2(sdft_pkg::OUTQ_DEPTH);

  sdft_pkg::bin_result_t   entries [sdft_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0]        head;
  logic [PTR_W-1:0]        tail;
  logic                    pop;
  sdft_pkg::bin_result_t   head_item;

  assign pop = bin_out.valid && bin_out.ready;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Present the oldest item
  always_comb begin
    head_item          = entries[head];
    bin_out.valid      = (count != '0);
    bin_out.bin_index  = head_item.bin_index;
    bin_out.real_red   = head_item.re[sdft_pkg::CH_RED];
    bin_out.real_green = head_item.re[sdft_pkg::CH_GREEN];
    bin_out.real_blue  = head_item.re[sdft_pkg::CH_BLUE];
    bin_out.imag_red   = head_item.im[sdft_pkg::CH_RED];
    bin_out.imag_green = head_item.im[sdft_pkg::CH_GREEN];
    bin_out.imag_blue  = head_item.im[sdft_pkg::CH_BLUE];
    bin_out.last_bin   = head_item.last_bin;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != sdft_pkg::OUTQ_CNT_W'(sdft_pkg::OUTQ_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

[hdl/per_pixel_sliding_dft_unit.sv]
// Top level: per-pixel sliding DFT sequencer with coefficient memory and result queue.
//
//  channel   role   handshake      carries
//  pix_in    sink   valid/ready    pixel position, new and old RGB samples
//  bin_out   source valid/ready    bin index, real/imag RGB coefficients, last flag
//
// An item issues one memory read per bin, (WINDOW_LEN-1)/2+1 bins capped at 8,
// so 8 reads per item at WINDOW_LEN=15, all through the single read port of the
// coefficient memory. Each result passes the read register, the stage 2 register
// and the result queue before it leaves. After reset a clearing pass zeroes all
// 2^(pixel bits + bin bits) rows (32768 at the defaults); no item is taken meanwhile.
// A stall at bin_out holds reads once the result queue has no room; an item for a
// pixel whose bins are still in flight waits until they are written back.
module per_pixel_sliding_dft_unit #(
  parameter int WINDOW_LEN   = sdft_pkg::WINDOW_LEN_DEF,
  parameter int FRAME_WIDTH  = sdft_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = sdft_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sdft_pix_if.sink    pix_in,
  sdft_bin_if.source  bin_out
);

  localparam int HALF_BINS  = (WINDOW_LEN - 1) / 2 + 1;
  localparam int NUM_BINS   = (HALF_BINS > sdft_pkg::MAX_BINS) ? sdft_pkg::MAX_BINS
                                                               : HALF_BINS;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int PIX_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIX_W      = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
  localparam int ADDR_W     = PIX_W + BIN_W;
  localparam int PIX_CALC_W = PIX_W + 13;
  localparam int OCC_W      = sdft_pkg::OUTQ_CNT_W + 1;
  localparam logic [sdft_pkg::BIN_IDX_W-1:0] LAST_BIN =
    sdft_pkg::BIN_IDX_W'(NUM_BINS - 1);

  sdft_pkg::seq_state_t  state;
  sdft_pkg::seq_state_t  state_next;
  logic [ADDR_W-1:0]     clr_addr;
  logic [sdft_pkg::BIN_IDX_W-1:0] bin_cnt;
  logic [PIX_W-1:0]      cur_pix;
  sdft_pkg::diff_vec_t   item_diff;

  logic [PIX_CALC_W-1:0] probe_full;
  logic [PIX_W-1:0]      probe_pix;
  logic                  in_frame;
  logic                  accept;
  logic                  hazard;
  logic                  issue;
  logic                  last_issue;
  logic                  credit_ok;
  logic                  clearing;
  logic [OCC_W-1:0]      occupancy;

  sdft_pkg::bin_tag_t    issue_tag;
  logic [ADDR_W-1:0]     rd_addr;
  sdft_pkg::coef_row_t   rd_data;
  logic                  wb_en;
  logic [ADDR_W-1:0]     wb_addr;
  sdft_pkg::coef_row_t   wb_data;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  sdft_pkg::coef_row_t   ram_wdata;
  logic                  res_valid;
  sdft_pkg::bin_result_t res;
  sdft_pkg::pipe_status_t status;
  logic [sdft_pkg::OUTQ_CNT_W-1:0] q_count;

  // Locate the offered pixel
  always_comb begin
    probe_full = PIX_CALC_W'(pix_in.pixel_y) * PIX_CALC_W'(FRAME_WIDTH) +
                 PIX_CALC_W'(pix_in.pixel_x);
    probe_pix  = probe_full[PIX_W-1:0];
    in_frame   = (13'(pix_in.pixel_x) < 13'(FRAME_WIDTH)) &&
                 (13'(pix_in.pixel_y) < 13'(FRAME_HEIGHT));
  end

  // Room downstream for one more bin, last-bin flag and pixel-in-flight hazard
  always_comb begin
    occupancy  = OCC_W'(q_count) + OCC_W'(status.s1_valid) + OCC_W'(status.s2_valid);
    credit_ok  = occupancy < OCC_W'(sdft_pkg::OUTQ_DEPTH);
    last_issue = (bin_cnt == LAST_BIN);
    hazard     = status.pix_hit || ((state == sdft_pkg::ST_RUN) && (cur_pix == probe_pix));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sdft_pkg::ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = sdft_pkg::ST_IDLE;
        end
      end
      sdft_pkg::ST_IDLE: begin
        if (accept && in_frame) begin
          state_next = sdft_pkg::ST_RUN;
        end
      end
      sdft_pkg::ST_RUN: begin
        if (issue && last_issue) begin
          state_next = (accept && in_frame) ? sdft_pkg::ST_RUN : sdft_pkg::ST_IDLE;
        end
      end
      default: state_next = sdft_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    clearing     = 1'b0;
    issue        = 1'b0;
    pix_in.ready = 1'b0;
    unique case (state)
      sdft_pkg::ST_CLEAR: begin
        clearing = 1'b1;
      end
      sdft_pkg::ST_IDLE: begin
        pix_in.ready = !hazard;
      end
      sdft_pkg::ST_RUN: begin
        issue        = credit_ok;
        pix_in.ready = credit_ok && last_issue && !hazard;
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  assign accept = pix_in.valid && pix_in.ready;

  // Hold state, sweep counter and bin counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sdft_pkg::ST_CLEAR;
      clr_addr <= '0;
      bin_cnt  <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        bin_cnt <= '0;
      end else if (issue && !last_issue) begin
        bin_cnt <= bin_cnt + 1'b1;
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pix <= probe_pix;
      item_diff[sdft_pkg::CH_RED]   <= 17'($signed(pix_in.new_red))   -
                                       17'($signed(pix_in.old_red));
      item_diff[sdft_pkg::CH_GREEN] <= 17'($signed(pix_in.new_green)) -
                                       17'($signed(pix_in.old_green));
      item_diff[sdft_pkg::CH_BLUE]  <= 17'($signed(pix_in.new_blue))  -
                                       17'($signed(pix_in.old_blue));
    end
  end

  // Issue one bin read
  always_comb begin
    rd_addr         = {cur_pix, bin_cnt[BIN_W-1:0]};
    issue_tag.valid = issue;
    issue_tag.bin   = bin_cnt;
    issue_tag.last  = last_issue;
  end

  // Clearing pass owns the write port until it ends
  always_comb begin
    ram_we    = clearing || wb_en;
    ram_waddr = clearing ? clr_addr : wb_addr;
    ram_wdata = clearing ? '0 : wb_data;
  end

  sdft_coef_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sdft_bin_datapath #(
    .WINDOW_LEN (WINDOW_LEN),
    .ADDR_W     (ADDR_W),
    .BIN_W      (BIN_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .issue_tag  (issue_tag),
    .issue_addr (rd_addr),
    .issue_diff (item_diff),
    .rd_data    (rd_data),
    .probe_pix  (probe_pix),
    .wb_en      (wb_en),
    .wb_addr    (wb_addr),
    .wb_data    (wb_data),
    .res_valid  (res_valid),
    .res        (res),
    .status     (status)
  );

  sdft_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .count     (q_count),
    .bin_out   (bin_out)
  );

`ifndef NO_ASSERTIONS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    issue && wb_en |-> rd_addr != wb_addr)
    else $error("read and write-back hit the same row");

  a_start_at_dc: assert property (@(posedge clk) disable iff (rst)
    accept && in_frame |=> state == sdft_pkg::ST_RUN && bin_cnt == sdft_pkg::DC_BIN)
    else $error("accepted item did not start at the DC bin");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    bin_out.valid && bin_out.last_bin |-> bin_out.bin_index == LAST_BIN)
    else $error("last flag on a bin other than the final one");
`endif

endmodule
